>>> hdl/s2dt_pkg.sv
// shared constants and the month table for the seconds to date/time converter
// no dependencies
package s2dt_pkg;

  localparam int REF_YEAR_DEF = 24;

  localparam int SECS_W   = 32;
  localparam int YEAR_W   = 8;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;

  // 86400 = 2^7 * 675: the low seconds bits bypass the divider
  localparam int SEC_LO_W        = 7;
  localparam int DAY_DIV         = 675;
  localparam int DAYS_PER_YEAR   = 365;
  localparam int DAYS_PER_LEAP   = 366;
  localparam int DAYS_PER_CYCLE  = 4 * DAYS_PER_YEAR + 1;
  localparam int SECS_PER_HOUR   = 3600;
  localparam int SECS_PER_MINUTE = 60;

  // start of each year within a four-year cycle that opens with a leap year
  localparam int YEAR1_START = DAYS_PER_LEAP;
  localparam int YEAR2_START = YEAR1_START + DAYS_PER_YEAR;
  localparam int YEAR3_START = YEAR2_START + DAYS_PER_YEAR;

  localparam int DOY_W = 9;

  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam int MONTHS = 12;

  // first day of month (zero-based index) within the year
  function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] mon,
                                                   input logic leap);
    logic [DOY_W-1:0] base;
    logic [DOY_W-1:0] adj;
    begin
      case (mon)
        4'd0:    base = 9'd0;
        4'd1:    base = 9'd31;
        4'd2:    base = 9'd59;
        4'd3:    base = 9'd90;
        4'd4:    base = 9'd120;
        4'd5:    base = 9'd151;
        4'd6:    base = 9'd181;
        4'd7:    base = 9'd212;
        4'd8:    base = 9'd243;
        4'd9:    base = 9'd273;
        4'd10:   base = 9'd304;
        4'd11:   base = 9'd334;
        default: base = 9'd0;
      endcase
      adj = (leap && (mon >= MONTH_FEB)) ? 9'd1 : 9'd0;
      month_start = base + adj;
    end
  endfunction

endpackage

>>> hdl/s2dt_ifs.sv
// valid/ready channel interfaces for the seconds to date/time converter
// depends on s2dt_pkg
interface s2dt_in_if;
  import s2dt_pkg::*;
  logic              valid;
  logic              ready;
  logic [SECS_W-1:0] elapsed_seconds;
  modport source (output valid, output elapsed_seconds, input ready);
  modport sink (input valid, input elapsed_seconds, output ready);
endinterface

interface s2dt_out_if;
  import s2dt_pkg::*;
  logic                valid;
  logic                ready;
  logic [YEAR_W-1:0]   year;
  logic [MONTH_W-1:0]  month;
  logic [DAY_W-1:0]    day;
  logic [HOUR_W-1:0]   hour;
  logic [MINUTE_W-1:0] minute;
  logic [SECOND_W-1:0] second_of_minute;
  modport source (output valid, output year, output month, output day, output hour,
                  output minute, output second_of_minute, input ready);
  modport sink (input valid, input year, input month, input day, input hour,
                input minute, input second_of_minute, output ready);
endinterface

>>> hdl/seconds_to_date_time.sv
// seconds to date/time converter top level: ten-stage pipeline
// depends on s2dt_pkg, s2dt_ifs and s2dt_cdiv
//
// in_chan takes a 32-bit count of seconds since 1 January of REF_YEAR, 00:00:00;
// out_chan gives year, month, day, hour, minute and second_of_minute for it.
// a transaction completes when valid and ready are both high at a clock edge.
// every input transaction yields exactly one output transaction, in order.
// throughput: one transaction per cycle while out_chan.ready does not stall it;
// each stage holds one item with its own valid bit. the depth comes from three
// rows of constant dividers of three stages each in series (seconds per day,
// then days per four-year cycle beside seconds per hour, then seconds per
// minute) plus the output register; the year and month decode runs beside the
// minute divider. when out_chan.ready is low the output register holds and
// stages behind it keep moving into empty slots, so in_chan.ready drops only
// once every stage is full. nothing is lost or repeated across a stall.
// reset (rst_n low, synchronous) clears every valid bit and so empties the
// pipeline; the data registers are not reset and keep their contents.
module seconds_to_date_time #(
  parameter int REF_YEAR = s2dt_pkg::REF_YEAR_DEF
) (
  input logic        clk,
  input logic        rst_n,
  s2dt_in_if.sink    in_chan,
  s2dt_out_if.source out_chan
);
  import s2dt_pkg::*;

  localparam int NSTG      = 10;
  localparam int PHASE     = REF_YEAR % 4;
  localparam int DAY_OFS   = (PHASE == 0) ? 0 : DAYS_PER_LEAP + DAYS_PER_YEAR * (PHASE - 1);
  localparam int YEAR_BASE = REF_YEAR - PHASE;

  localparam int DXW = SECS_W - SEC_LO_W;
  localparam int DQW = $clog2((2 ** DXW) / DAY_DIV + 1);
  localparam int DRW = $clog2(DAY_DIV);
  localparam int CXW = DQW;
  localparam int CQW = $clog2((2 ** CXW) / DAYS_PER_CYCLE + 1);
  localparam int CRW = $clog2(DAYS_PER_CYCLE);
  localparam int HXW = DRW + SEC_LO_W;
  localparam int HQW = $clog2((2 ** HXW) / SECS_PER_HOUR + 1);
  localparam int HRW = $clog2(SECS_PER_HOUR);
  localparam int MXW = HRW;
  localparam int MQW = $clog2((2 ** MXW) / SECS_PER_MINUTE + 1);
  localparam int MRW = $clog2(SECS_PER_MINUTE);

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] en;

  // stall chain: a stage loads when it is empty or its content moves on
  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_chan.ready;
    for (int s = NSTG - 2; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end

  assign in_chan.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_chan.valid;
      end
      for (int s = 1; s < NSTG; s++) begin
        if (en[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  // stages 0..2: whole days and second of day
  logic [SEC_LO_W-1:0] sec_lo_r0;
  logic [SEC_LO_W-1:0] sec_lo_r1;
  logic [SEC_LO_W-1:0] sec_lo_r2;
  logic [DQW-1:0]      day_q;
  logic [DRW-1:0]      day_rm;

  s2dt_cdiv #(.XW(DXW), .DIV(DAY_DIV), .QW(DQW), .RW(DRW)) u_day_div (
    .clk (clk),
    .en  (en[2:0]),
    .x   (in_chan.elapsed_seconds[SECS_W-1:SEC_LO_W]),
    .q   (day_q),
    .r   (day_rm)
  );

  // stages 3..5: four-year cycles and hour of day
  logic [CXW-1:0] cyc_x;
  logic [HXW-1:0] sod;
  logic [CQW-1:0] cyc_q;
  logic [CRW-1:0] cyc_rm;
  logic [HQW-1:0] hr_q;
  logic [HRW-1:0] hr_rm;

  assign cyc_x = CXW'((CXW+1)'(day_q) + (CXW+1)'(DAY_OFS));
  assign sod   = {day_rm, sec_lo_r2};

  s2dt_cdiv #(.XW(CXW), .DIV(DAYS_PER_CYCLE), .QW(CQW), .RW(CRW)) u_cyc_div (
    .clk (clk),
    .en  (en[5:3]),
    .x   (cyc_x),
    .q   (cyc_q),
    .r   (cyc_rm)
  );

  s2dt_cdiv #(.XW(HXW), .DIV(SECS_PER_HOUR), .QW(HQW), .RW(HRW)) u_hr_div (
    .clk (clk),
    .en  (en[5:3]),
    .x   (sod),
    .q   (hr_q),
    .r   (hr_rm)
  );

  // stages 6..8: minute and second
  logic [MQW-1:0] min_q;
  logic [MRW-1:0] min_rm;

  s2dt_cdiv #(.XW(MXW), .DIV(SECS_PER_MINUTE), .QW(MQW), .RW(MRW)) u_min_div (
    .clk (clk),
    .en  (en[8:6]),
    .x   (hr_rm),
    .q   (min_q),
    .r   (min_rm)
  );

  // stage 6: year within the cycle and day of year
  logic [1:0]       yi_nxt;
  logic [DOY_W-1:0] doy_nxt;

  always_comb begin
    if (cyc_rm < CRW'(YEAR1_START)) begin
      yi_nxt  = 2'd0;
      doy_nxt = DOY_W'(cyc_rm);
    end else if (cyc_rm < CRW'(YEAR2_START)) begin
      yi_nxt  = 2'd1;
      doy_nxt = DOY_W'(cyc_rm - CRW'(YEAR1_START));
    end else if (cyc_rm < CRW'(YEAR3_START)) begin
      yi_nxt  = 2'd2;
      doy_nxt = DOY_W'(cyc_rm - CRW'(YEAR2_START));
    end else begin
      yi_nxt  = 2'd3;
      doy_nxt = DOY_W'(cyc_rm - CRW'(YEAR3_START));
    end
  end

  logic [1:0]        yi_r6;
  logic [DOY_W-1:0]  doy_r6;
  logic [CQW-1:0]    cyc_r6;
  logic [HOUR_W-1:0] hour_r6;

  // stage 7: month, day of month and year
  logic              leap7;
  logic [MONTH_W-1:0] mon_idx;
  logic [DOY_W-1:0]  day_ofs;
  logic [YEAR_W-1:0] year_nxt;

  assign leap7 = (yi_r6 == 2'd0);

  always_comb begin
    mon_idx = '0;
    for (int i = 1; i < MONTHS; i++) begin
      if (doy_r6 >= month_start(MONTH_W'(i), leap7)) begin
        mon_idx = MONTH_W'(i);
      end
    end
  end

  assign day_ofs  = doy_r6 - month_start(mon_idx, leap7);
  assign year_nxt = YEAR_W'(YEAR_BASE) + YEAR_W'({cyc_r6, yi_r6});

  logic [YEAR_W-1:0]  year_r7;
  logic [MONTH_W-1:0] month_r7;
  logic [DAY_W-1:0]   day_r7;
  logic [HOUR_W-1:0]  hour_r7;
  logic [YEAR_W-1:0]  year_r8;
  logic [MONTH_W-1:0] month_r8;
  logic [DAY_W-1:0]   day_r8;
  logic [HOUR_W-1:0]  hour_r8;

  logic [YEAR_W-1:0]   year_r;
  logic [MONTH_W-1:0]  month_r;
  logic [DAY_W-1:0]    day_r;
  logic [HOUR_W-1:0]   hour_r;
  logic [MINUTE_W-1:0] minute_r;
  logic [SECOND_W-1:0] second_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sec_lo_r0 <= in_chan.elapsed_seconds[SEC_LO_W-1:0];
    end
    if (en[1]) begin
      sec_lo_r1 <= sec_lo_r0;
    end
    if (en[2]) begin
      sec_lo_r2 <= sec_lo_r1;
    end
    if (en[6]) begin
      yi_r6   <= yi_nxt;
      doy_r6  <= doy_nxt;
      cyc_r6  <= cyc_q;
      hour_r6 <= HOUR_W'(hr_q);
    end
    if (en[7]) begin
      year_r7  <= year_nxt;
      month_r7 <= MONTH_W'(mon_idx + 1'b1);
      day_r7   <= DAY_W'(day_ofs + 1'b1);
      hour_r7  <= hour_r6;
    end
    if (en[8]) begin
      year_r8  <= year_r7;
      month_r8 <= month_r7;
      day_r8   <= day_r7;
      hour_r8  <= hour_r7;
    end
    if (en[9]) begin
      year_r   <= year_r8;
      month_r  <= month_r8;
      day_r    <= day_r8;
      hour_r   <= hour_r8;
      minute_r <= MINUTE_W'(min_q);
      second_r <= SECOND_W'(min_rm);
    end
  end

  assign out_chan.valid            = v_r[NSTG-1];
  assign out_chan.year             = year_r;
  assign out_chan.month            = month_r;
  assign out_chan.day              = day_r;
  assign out_chan.hour             = hour_r;
  assign out_chan.minute           = minute_r;
  assign out_chan.second_of_minute = second_r;

endmodule

>>> hdl/s2dt_cdiv.sv
// three-stage divider by a constant: reciprocal multiply, back-multiply, one correction
// no dependencies
module s2dt_cdiv #(
  parameter int XW  = 16,
  parameter int DIV = 10,
  parameter int QW  = 13,
  parameter int RW  = 4
) (
  input  logic          clk,
  input  logic [2:0]    en,
  input  logic [XW-1:0] x,
  output logic [QW-1:0] q,
  output logic [RW-1:0] r
);

  localparam longint unsigned RECIP = (64'd1 << XW) / DIV;
  localparam int MW = $clog2(RECIP + 1);
  localparam int PW = XW + MW;

  logic [XW-1:0] x_a_r;
  logic [PW-1:0] p_a_r;
  logic [XW-1:0] x_b_r;
  logic [QW-1:0] q_b_r;
  logic [XW-1:0] m_b_r;
  logic [QW-1:0] q_c_r;
  logic [RW-1:0] r_c_r;

  logic [QW-1:0] q_est;
  logic [XW-1:0] r_full;
  logic [RW:0]   r_lo;
  logic [QW-1:0] q_c_nxt;
  logic [RW-1:0] r_c_nxt;

  assign q_est  = QW'(p_a_r >> XW);
  assign r_full = x_b_r - m_b_r;
  assign r_lo   = r_full[RW:0];

  always_comb begin
    if (r_lo >= (RW+1)'(DIV)) begin
      q_c_nxt = QW'(q_b_r + 1'b1);
      r_c_nxt = RW'(r_lo - (RW+1)'(DIV));
    end else begin
      q_c_nxt = q_b_r;
      r_c_nxt = RW'(r_lo);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_a_r <= x;
      p_a_r <= PW'(x) * PW'(RECIP);
    end
    if (en[1]) begin
      x_b_r <= x_a_r;
      q_b_r <= q_est;
      m_b_r <= XW'(q_est) * XW'(DIV);
    end
    if (en[2]) begin
      q_c_r <= q_c_nxt;
      r_c_r <= r_c_nxt;
    end
  end

  assign q = q_c_r;
  assign r = r_c_r;

endmodule

>>> hdl/s2dt_checker.sv
// port-level checks on the result channel of seconds_to_date_time, with its bind
// depends on s2dt_pkg and seconds_to_date_time
module s2dt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [s2dt_pkg::YEAR_W-1:0]   year,
  input logic [s2dt_pkg::MONTH_W-1:0]  month,
  input logic [s2dt_pkg::DAY_W-1:0]    day,
  input logic [s2dt_pkg::HOUR_W-1:0]   hour,
  input logic [s2dt_pkg::MINUTE_W-1:0] minute,
  input logic [s2dt_pkg::SECOND_W-1:0] second_of_minute
);
  import s2dt_pkg::*;

  // a stalled transaction stays offered
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (month >= MONTH_W'(1)) && (month <= MONTH_W'(MONTHS)) &&
                  (day >= DAY_W'(1)) && (hour <= HOUR_W'(23)) &&
                  (minute <= MINUTE_W'(59)) && (second_of_minute <= SECOND_W'(59)))
    else $error("result field out of range");

  // february length follows the leap rule
  a_feb_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (month == MONTH_FEB) |->
      (day <= DAY_W'(28)) || ((day == DAY_W'(29)) && (year[1:0] == 2'b00)))
    else $error("bad february day");

endmodule

bind seconds_to_date_time s2dt_checker u_s2dt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .year             (out_chan.year),
  .month            (out_chan.month),
  .day              (out_chan.day),
  .hour             (out_chan.hour),
  .minute           (out_chan.minute),
  .second_of_minute (out_chan.second_of_minute)
);

>>> dv/testbench.sv
// testbench for seconds_to_date_time: random and boundary second counts in, calendar fields out
// depends on s2dt_pkg, s2dt_ifs and the seconds_to_date_time rtl
// a scoreboard class predicts each date and checks results in order under random stalls
`timescale 1ns / 1ps

module testbench;
  import s2dt_pkg::*;

  localparam int unsigned SECS_PER_DAY = 24 * SECS_PER_HOUR;
  localparam int unsigned MONTH_DAYS [MONTHS] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int DIRECTED_CNT = 22;
  localparam int BACKLOG_CNT  = 40;
  localparam int RANDOM_CNT   = 1190;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second_of_minute;
  } date_time_t;

  function automatic int unsigned year_len(int unsigned yr);
    return (yr % 4 == 0) ? DAYS_PER_LEAP : DAYS_PER_YEAR;
  endfunction

  class calendar_scoreboard;
    date_time_t pending_dates[$];
    int         mismatches;

    function date_time_t to_calendar(logic [SECS_W-1:0] secs);
      date_time_t  r;
      int unsigned days;
      int unsigned sod;
      int unsigned yr;
      int unsigned mon;
      int unsigned mlen;
      bit          leap;
      days = secs / SECS_PER_DAY;
      sod  = secs % SECS_PER_DAY;
      yr   = REF_YEAR_DEF;
      while (days >= year_len(yr)) begin
        days -= year_len(yr);
        yr++;
      end
      leap = (yr % 4 == 0);
      mon  = 0;
      while (mon < MONTHS - 1) begin
        mlen = MONTH_DAYS[mon] + ((mon == 1 && leap) ? 1 : 0);
        if (days < mlen) break;
        days -= mlen;
        mon++;
      end
      r.year             = YEAR_W'(yr);
      r.month            = MONTH_W'(mon + 1);
      r.day              = DAY_W'(days + 1);
      r.hour             = HOUR_W'(sod / SECS_PER_HOUR);
      r.minute           = MINUTE_W'((sod % SECS_PER_HOUR) / SECS_PER_MINUTE);
      r.second_of_minute = SECOND_W'(sod % SECS_PER_MINUTE);
      return r;
    endfunction

    function void note_seconds(logic [SECS_W-1:0] secs);
      pending_dates.push_back(to_calendar(secs));
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_date(date_time_t got);
      date_time_t want;
      if (pending_dates.size() == 0) begin
        $error("unexpected result transaction %0d-%0d-%0d %0d:%0d:%0d", got.year, got.month,
               got.day, got.hour, got.minute, got.second_of_minute);
        mismatches++;
        return;
      end
      want = pending_dates.pop_front();
      check_field("year", want.year, got.year);
      check_field("month", want.month, got.month);
      check_field("day", want.day, got.day);
      check_field("hour", want.hour, got.hour);
      check_field("minute", want.minute, got.minute);
      check_field("second_of_minute", want.second_of_minute, got.second_of_minute);
    endfunction

    function int pending();
      return pending_dates.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   start_backlog;
  bit   backlog_hold;
  int   results_seen;
  int   leap_days_seen;
  int   max_year_seen;

  calendar_scoreboard sb;

  s2dt_in_if  in_chan ();
  s2dt_out_if out_chan ();

  seconds_to_date_time #(
    .REF_YEAR(REF_YEAR_DEF)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint days_before_year(int unsigned yr);
    longint d;
    d = 0;
    for (int unsigned y = REF_YEAR_DEF; y < yr; y++) d += year_len(y);
    return d;
  endfunction

  function automatic logic [SECS_W-1:0] random_seconds();
    int          r;
    int unsigned yr;
    int unsigned mon;
    longint      d;
    longint      t;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom();
    if (r < 55) begin
      d = $urandom_range(0, 49710);
      case ($urandom_range(0, 5))
        0:       t = d * SECS_PER_DAY;
        1:       t = d * SECS_PER_DAY + SECS_PER_DAY - 1;
        2:       t = d * SECS_PER_DAY + SECS_PER_HOUR * $urandom_range(0, 23) - 1;
        3:       t = d * SECS_PER_DAY + SECS_PER_MINUTE * $urandom_range(0, 1439);
        default: t = d * SECS_PER_DAY + $urandom_range(0, SECS_PER_DAY - 1);
      endcase
    end else if (r < 85) begin
      yr  = REF_YEAR_DEF + $urandom_range(0, 135);
      mon = $urandom_range(0, MONTHS - 1);
      d   = days_before_year(yr);
      for (int unsigned m = 0; m < mon; m++)
        d += MONTH_DAYS[m] + ((m == 1 && yr % 4 == 0) ? 1 : 0);
      d += int'($urandom_range(0, 2)) - 1;
      if ($urandom_range(0, 3) == 0) d += 27 + $urandom_range(0, 1);
      t = d * SECS_PER_DAY + $urandom_range(0, SECS_PER_DAY - 1);
    end else begin
      t = $urandom_range(0, 5 * DAYS_PER_LEAP * SECS_PER_DAY);
    end
    if (t < 0) t = 0;
    return SECS_W'(t);
  endfunction

  task automatic send_seconds(input logic [SECS_W-1:0] secs, input bit allow_gap);
    int gap;
    gap = allow_gap ? pick_gap() : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid           <= 1'b1;
    in_chan.elapsed_seconds <= secs;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_seconds(secs);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // receiver side: random stalls in phases, plus the long backlog hold
  initial begin
    int stall_left;
    int phase_left;
    bit idle_on;
    date_time_t got;
    stall_left = 0;
    phase_left = 0;
    idle_on    = 1'b1;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_chan.valid && out_chan.ready) begin
        got = '{out_chan.year, out_chan.month, out_chan.day, out_chan.hour, out_chan.minute,
                out_chan.second_of_minute};
        sb.check_date(got);
        results_seen++;
        if (got.month == MONTH_FEB && got.day == DAY_W'(29)) leap_days_seen++;
        if (int'(got.year) > max_year_seen) max_year_seen = got.year;
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(100, 400);
        idle_on    = $urandom_range(0, 3) != 0;
      end
      phase_left--;
      if (stall_left > 0) stall_left--;
      else if (idle_on) stall_left = pick_gap();
      out_chan.ready <= rst_n && !backlog_hold && stall_left == 0;
    end
  end

  // long receiver hold so the pipeline fills and back-pressures the input
  initial begin
    backlog_hold = 1'b0;
    @(negedge clk);
    while (!start_backlog) @(negedge clk);
    backlog_hold = 1'b1;
    repeat (80) @(negedge clk);
    backlog_hold = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [SECS_W-1:0] directed [DIRECTED_CNT];
    bit                gaps_on;
    sb = new();
    start_backlog  = 1'b0;
    results_seen   = 0;
    leap_days_seen = 0;
    max_year_seen  = 0;
    directed = '{
      32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      31 * SECS_PER_DAY - 1,                           // last second of january
      (31 + 27) * SECS_PER_DAY,                        // feb 28 of a leap year
      (31 + 28) * SECS_PER_DAY + SECS_PER_DAY - 1,     // leap day, last second
      (31 + 29) * SECS_PER_DAY,                        // march 1 after leap day
      DAYS_PER_LEAP * SECS_PER_DAY - 1,                // new year's eve of a leap year
      DAYS_PER_LEAP * SECS_PER_DAY,
      (DAYS_PER_LEAP + 58) * SECS_PER_DAY + 43200,     // feb 28 of a common year
      (DAYS_PER_LEAP + 59) * SECS_PER_DAY,             // march 1 of a common year
      (DAYS_PER_CYCLE + 59) * SECS_PER_DAY,            // leap day four years later
      32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF
    };
    rst_n                   <= 1'b0;
    in_chan.valid           <= 1'b0;
    in_chan.elapsed_seconds <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_seconds(directed[i], 1'b1);
    in_chan.valid <= 1'b0;
    wait_drained();

    start_backlog = 1'b1;
    for (int i = 0; i < BACKLOG_CNT; i++) send_seconds(random_seconds(), 1'b0);

    gaps_on = 1'b1;
    for (int i = 0; i < RANDOM_CNT; i++) begin
      if (i % 150 == 0) gaps_on = $urandom_range(0, 2) != 0;
      send_seconds(random_seconds(), gaps_on);
    end
    in_chan.valid <= 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    $display("converted %0d second counts incl. full-range extremes and stalls", results_seen);
    $display("%0d leap-day dates seen, years up to %0d", leap_days_seen, max_year_seen);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> seconds_to_date_time.f
hdl/s2dt_pkg.sv
hdl/s2dt_ifs.sv
hdl/s2dt_cdiv.sv
hdl/seconds_to_date_time.sv
hdl/s2dt_checker.sv
dv/testbench.sv
